// File: hw/rtl/gmwp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmwp_pkg: shared types and codes for the grid max-weight path engine
// Beat layouts for the edge input and result output, config register
// indexes and status codes.
// ----------------------------------------------------------------------------
package gmwp_pkg;

  // Fixed field widths
  localparam int NODE_FIELD_W = 10;
  localparam int IN_WEIGHT_W  = 16;
  localparam int GRID_DIM_W   = 11;
  localparam int TOTAL_W      = 32;
  localparam int STATUS_W     = 2;

  // Config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GRID_DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_EDGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 2'd2;

  // One edge beat
  typedef struct packed {
    logic [NODE_FIELD_W-1:0] edge_source;
    logic [NODE_FIELD_W-1:0] edge_dest;
    logic [IN_WEIGHT_W-1:0]  edge_weight;
    logic                    last_edge;
  } edge_item_t;

  // One result beat
  typedef struct packed {
    logic [TOTAL_W-1:0]  best_total;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/grid_max_weight_path.sv
`default_nettype none
// Sequence: an edge beat is accepted (reading its source slot), then its slot
// is written back; the last beat then latches n = rows*cols, and each node is
// scored on one shared adder (no sweep if n <= 1 or too big).
// A new edge is accepted only once the previous edge's slot write is done.
// Reset and each result start a clearing pass over all MAX_NODES edge store
// slots during which input is stalled; config writes are taken anytime.
// ----------------------------------------------------------------------------
// grid_max_weight_path: maximum-weight path over a grid DAG
// Keeps the two newest edges per source node in an on-chip store, then on the
// last edge zeroes node n-1 and sweeps n-2 down to 0 for the best path score.
// ----------------------------------------------------------------------------
module grid_max_weight_path #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // config write port
  input  wire                                 cfg_we,
  input  wire [gmwp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [gmwp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // edge input
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  gmwp_pkg::edge_item_t                in_data,
  // result output
  output logic                                out_valid,
  input  wire                                 out_stall,
  output gmwp_pkg::result_t                   out_data
);
  import gmwp_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int NW = 2 * GRID_DIM_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_CHECK = 4'd3;
  localparam logic [3:0] ST_RDE   = 4'd4;
  localparam logic [3:0] ST_SC1   = 4'd5;
  localparam logic [3:0] ST_SC1W  = 4'd6;
  localparam logic [3:0] ST_SC2   = 4'd7;
  localparam logic [3:0] ST_CLEAR = 4'd8;

  // Edge store slot: count plus newest (1) and previous (2) edge
  typedef struct packed {
    logic [1:0]              cnt;
    logic [NODE_FIELD_W-1:0] d1;
    logic [SW-1:0]           w1;
    logic [NODE_FIELD_W-1:0] d2;
    logic [SW-1:0]           w2;
  } slot_t;

  slot_t             edge_mem [MAX_NODES];
  logic [TOTAL_W-1:0] best_mem [MAX_NODES];

  logic [3:0]              state;
  logic [AW-1:0]           clr;
  logic                    bad_edge_seen;
  logic [GRID_DIM_W-1:0]   grid_rows;
  logic [GRID_DIM_W-1:0]   grid_cols;

  logic [AW-1:0]           ld_addr;
  logic [NODE_FIELD_W-1:0] ld_src;
  logic [NODE_FIELD_W-1:0] ld_dst;
  logic [SW-1:0]           ld_w;
  logic                    ld_last;
  logic                    ld_good;
  logic [NW-1:0]           n_reg;
  logic [AW-1:0]           v;
  logic [TOTAL_W-1:0]      score_a;
  logic                    sweep_bad;

  slot_t                   edge_q;
  logic [TOTAL_W-1:0]      best_q;

  // Memory port controls
  logic                    edge_re;
  logic [AW-1:0]           edge_ra;
  logic                    edge_we;
  logic [AW-1:0]           edge_wa;
  slot_t                   edge_wd;
  logic                    best_re;
  logic [AW-1:0]           best_ra;
  logic                    best_we;
  logic [AW-1:0]           best_wa;
  logic [TOTAL_W-1:0]      best_wd;

  // Decode of the incoming beat
  logic [31:0]             src_wide;
  logic [AW-1:0]           src_addr;
  logic                    in_good;
  logic                    in_acc;

  // Sweep helpers
  logic                    too_big;
  logic [AW-1:0]           n_last;
  logic [31:0]             d1_wide;
  logic [31:0]             d2_wide;
  logic                    d1_in;
  logic                    d2_in;
  logic                    use_a;
  logic                    use_b;
  logic                    flag_a;
  logic                    flag_b;
  logic [SW-1:0]           unit_w;
  logic [TOTAL_W:0]        unit_sum;
  logic [TOTAL_W-1:0]      unit_sat;
  logic [TOTAL_W-1:0]      score_b;
  logic [TOTAL_W-1:0]      node_best;
  logic                    bad_now;
  slot_t                   slot_new;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Incoming edge checks
  assign src_wide = 32'(in_data.edge_source);
  assign src_addr = src_wide[AW-1:0];
  assign in_good  = (in_data.edge_dest > in_data.edge_source) &&
                    (src_wide < 32'(MAX_NODES));

  // Grid size checks
  assign too_big = 32'(n_reg) > 32'(MAX_NODES);
  assign n_last  = AW'(n_reg - NW'(1));

  // Destination checks against the grid
  assign d1_wide = 32'(edge_q.d1);
  assign d2_wide = 32'(edge_q.d2);
  assign d1_in   = d1_wide < 32'(n_reg);
  assign d2_in   = d2_wide < 32'(n_reg);
  assign use_a   = (edge_q.cnt != 2'd0);
  assign use_b   = edge_q.cnt[1];
  assign flag_a  = use_a && !d1_in;
  assign flag_b  = use_b && !d2_in;

  // Shared saturating adder: weight of the current edge plus best of its dest
  assign unit_w   = (state == ST_SC2) ? edge_q.w2 : edge_q.w1;
  assign unit_sum = {1'b0, best_q} + (TOTAL_W + 1)'(unit_w);
  assign unit_sat = unit_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : unit_sum[TOTAL_W-1:0];

  assign score_b   = (use_b && d2_in) ? unit_sat : '0;
  assign node_best = (score_a > score_b) ? score_a : score_b;
  assign bad_now   = sweep_bad || flag_b;

  // Updated slot for a loaded edge
  always_comb begin
    slot_new     = edge_q;
    slot_new.d2  = edge_q.d1;
    slot_new.w2  = edge_q.w1;
    slot_new.d1  = ld_dst;
    slot_new.w1  = ld_w;
    slot_new.cnt = edge_q.cnt[1] ? 2'd2 : (edge_q.cnt + 2'd1);
  end

  // Memory port steering
  always_comb begin
    edge_re = 1'b0;
    edge_ra = v;
    edge_we = 1'b0;
    edge_wa = ld_addr;
    edge_wd = slot_new;
    best_re = 1'b0;
    best_ra = d1_wide[AW-1:0];
    best_we = 1'b0;
    best_wa = v;
    best_wd = node_best;
    case (state)
      ST_IDLE: begin
        edge_re = in_acc;
        edge_ra = src_addr;
      end
      ST_LOAD: begin
        edge_we = ld_good;
      end
      ST_CHECK: begin
        best_we = !out_valid && !too_big && (n_reg != '0);
        best_wa = n_last;
        best_wd = '0;
      end
      ST_RDE: begin
        edge_re = 1'b1;
      end
      ST_SC1: begin
        best_re = 1'b1;
      end
      ST_SC1W: begin
        best_re = 1'b1;
        best_ra = d2_wide[AW-1:0];
      end
      ST_SC2: begin
        best_we = 1'b1;
      end
      ST_CLEAR: begin
        edge_we = 1'b1;
        edge_wa = clr;
        edge_wd = '0;
      end
      default: begin
      end
    endcase
  end

  // Edge store
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    if (edge_re) begin
      edge_q <= edge_mem[edge_ra];
    end
  end

  // Per-node best score store
  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_wa] <= best_wd;
    end
    if (best_re) begin
      best_q <= best_mem[best_ra];
    end
  end

  // Sequencer, config registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr           <= '0;
      bad_edge_seen <= 1'b0;
      out_valid     <= 1'b0;
      grid_rows     <= GRID_DIM_W'(1);
      grid_cols     <= GRID_DIM_W'(1);
    end else begin
      // config writes
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_ROWS: grid_rows <= cfg_data;
          REG_GRID_COLS: grid_cols <= cfg_data;
          default: begin
          end
        endcase
      end

      // result beat taken
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ld_addr <= src_addr;
            ld_src  <= in_data.edge_source;
            ld_dst  <= in_data.edge_dest;
            ld_w    <= in_data.edge_weight[SW-1:0];
            ld_last <= in_data.last_edge;
            ld_good <= in_good;
            if (!in_good) begin
              bad_edge_seen <= 1'b1;
            end
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ld_last ? ST_START : ST_IDLE;
        end
        ST_START: begin
          n_reg <= NW'(grid_rows) * NW'(grid_cols);
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          // wait for a free result register before the sweep
          if (!out_valid) begin
            sweep_bad <= bad_edge_seen;
            if (too_big || n_reg <= NW'(1)) begin
              out_valid           <= 1'b1;
              out_data.best_total <= '0;
              out_data.status     <= too_big ? STATUS_TOO_BIG :
                                     (bad_edge_seen ? STATUS_BAD_EDGE : STATUS_OK);
              bad_edge_seen       <= 1'b0;
              clr                 <= '0;
              state               <= ST_CLEAR;
            end else begin
              v     <= AW'(n_reg - NW'(2));
              state <= ST_RDE;
            end
          end
        end
        ST_RDE: begin
          state <= ST_SC1;
        end
        ST_SC1: begin
          state <= ST_SC1W;
        end
        ST_SC1W: begin
          score_a   <= (use_a && d1_in) ? unit_sat : '0;
          sweep_bad <= sweep_bad || flag_a;
          state     <= ST_SC2;
        end
        ST_SC2: begin
          sweep_bad <= bad_now;
          if (v == '0) begin
            out_valid           <= 1'b1;
            out_data.best_total <= node_best;
            out_data.status     <= bad_now ? STATUS_BAD_EDGE : STATUS_OK;
            bad_edge_seen       <= 1'b0;
            clr                 <= '0;
            state               <= ST_CLEAR;
          end else begin
            v     <= v - AW'(1);
            state <= ST_RDE;
          end
        end
        ST_CLEAR: begin
          if (clr == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            clr <= clr + AW'(1);
          end
        end
        default: begin
          state <= ST_CLEAR;
          clr   <= '0;
        end
      endcase
    end
  end

  // Node written during the sweep lies inside the grid
  a_sweep_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SC2) |-> (32'(v) < 32'(n_reg)))
    else $error("sweep node outside grid");

  // A result leaves the bad-edge flag cleared and starts the clearing pass
  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (!bad_edge_seen && state == ST_CLEAR && clr == '0))
    else $error("result without store clear");

  // Only forward edges are written to the store
  a_forward_store: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && ld_good) |-> (ld_dst > ld_src))
    else $error("backward edge stored");

endmodule
`default_nettype wire
